@@ rtl/fept_pkg.sv @@
// Package for the FIFO-evicting peer table: request and status codes, field
// widths, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package fept_pkg;

  // Field widths of the stream words.
  localparam int REQ_W      = 2;
  localparam int KEY_W      = 32;
  localparam int PAY_W      = 32;
  localparam int SEL_W      = 4;
  localparam int STAT_W     = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNUSED    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_LINK_RD,
    S_UNLINK,
    S_APPEND_A,
    S_APPEND_B,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic take_free;
    logic link_rd;
    logic unlink;
    logic append_a;
    logic append_b;
    logic resp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             sel_ok;
    logic             scan_hit;
    logic             scan_last;
    logic             free_any;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/fept_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fept_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fept_dp.sv @@
// Datapath of the peer table: request registers, used marks, list ends,
// key/payload/link memories, the serial key scan and the result register.
// Depends on fept_pkg and fept_ram.
`default_nettype none

module fept_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fept_pkg::cmd_t                 cmd,
  output fept_pkg::sts_t                      sts,
  input  wire logic [fept_pkg::REQ_W-1:0]     in_req,
  input  wire logic [fept_pkg::KEY_W-1:0]     in_key,
  input  wire logic [fept_pkg::PAY_W-1:0]     in_pay,
  input  wire logic [fept_pkg::SEL_W-1:0]     in_sel,
  output logic      [fept_pkg::STAT_W-1:0]    res_status,
  output logic      [fept_pkg::SLOT_OUT_W-1:0] res_slot,
  output logic                                res_evicted
);
  import fept_pkg::*;

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int LW = $clog2(TABLE_SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(TABLE_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

  // Request registers.
  logic [REQ_W-1:0] req_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [SEL_W-1:0] sel_r;

  // Table control state.
  logic          used_r [TABLE_SLOTS];
  logic [LW-1:0] oldest_r, oldest_nxt;
  logic [LW-1:0] newest_r, newest_nxt;

  // Scan and operation state.
  logic [LW-1:0] rd_cnt_r;
  logic          cmp_vld_r;
  logic [SW-1:0] cmp_idx_r;
  logic          hit_r;
  logic [SW-1:0] hit_idx_r;
  logic          free_vld_r;
  logic [SW-1:0] free_idx_r;
  logic          evict_r;
  logic [SW-1:0] tgt_r;

  // Memory ports.
  logic [KEY_W-1:0] key_rd;
  logic             key_rd_en;
  logic             key_wr_en;
  logic [LW-1:0]    next_rd, prev_rd;
  logic             next_wr_en, prev_wr_en;
  logic [SW-1:0]    next_wr_addr, prev_wr_addr;
  logic [LW-1:0]    next_wr_data, prev_wr_data;
  logic [SW-1:0]    link_addr;

  // Scan compare on the word read in the previous cycle.
  logic cur_free, scan_hit, sel_in_range;

  assign cur_free     = cmp_vld_r && !used_r[cmp_idx_r];
  assign scan_hit     = cmp_vld_r && used_r[cmp_idx_r] && (key_rd == key_r);
  assign sel_in_range = 32'(sel_r) < 32'(TABLE_SLOTS);
  assign key_rd_en    = cmd.scan_step && (rd_cnt_r < NONE);

  // The entry to unlink: the oldest one on an eviction, else the selected slot.
  assign link_addr = (req_r == REQ_ADD) ? oldest_r[SW-1:0] : SW'(sel_r);

  assign sts.req       = req_r;
  assign sts.sel_ok    = sel_in_range && used_r[SW'(sel_r)];
  assign sts.scan_hit  = scan_hit;
  assign sts.scan_last = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign sts.free_any  = free_vld_r || cur_free;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req;
      key_r <= in_key;
      pay_r <= in_pay;
      sel_r <= in_sel;
    end
  end

  // Scan counters, hit and free slot tracking, target slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
      evict_r    <= 1'b0;
    end else if (cmd.accept) begin
      rd_cnt_r   <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
      evict_r    <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        cmp_vld_r <= key_rd_en;
        if (key_rd_en) begin
          rd_cnt_r <= rd_cnt_r + LW'(1);
        end
        if (scan_hit) begin
          hit_r <= 1'b1;
        end
        if (cur_free && !free_vld_r) begin
          free_vld_r <= 1'b1;
        end
      end
      // An entry is being unlinked: the eviction of an add or a remove.
      if (cmd.link_rd) begin
        evict_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx_r <= rd_cnt_r[SW-1:0];
      if (scan_hit) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (cur_free && !free_vld_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.link_rd) begin
      tgt_r <= link_addr;
    end else if (cmd.take_free) begin
      tgt_r <= free_vld_r ? free_idx_r : cmp_idx_r;
    end
  end

  // List end pointers.
  always_comb begin
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    if (cmd.unlink) begin
      if (oldest_r == LW'(tgt_r)) begin
        oldest_nxt = next_rd;
      end
      if (newest_r == LW'(tgt_r)) begin
        newest_nxt = prev_rd;
      end
    end else if (cmd.append_a) begin
      if (newest_r == NONE) begin
        oldest_nxt = LW'(tgt_r);
      end
      newest_nxt = LW'(tgt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= NONE;
      newest_r <= NONE;
    end else begin
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
    end
  end

  // Used marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        used_r[i] <= 1'b0;
      end
    end else if (cmd.unlink) begin
      used_r[tgt_r] <= 1'b0;
    end else if (cmd.append_b) begin
      used_r[tgt_r] <= 1'b1;
    end
  end

  // Link memory write selection for unlink and append.
  always_comb begin
    next_wr_en   = 1'b0;
    next_wr_addr = tgt_r;
    next_wr_data = NONE;
    prev_wr_en   = 1'b0;
    prev_wr_addr = tgt_r;
    prev_wr_data = newest_r;
    if (cmd.unlink) begin
      next_wr_en   = prev_rd != NONE;
      next_wr_addr = prev_rd[SW-1:0];
      next_wr_data = next_rd;
      prev_wr_en   = next_rd != NONE;
      prev_wr_addr = next_rd[SW-1:0];
      prev_wr_data = prev_rd;
    end else if (cmd.append_a) begin
      next_wr_en   = newest_r != NONE;
      next_wr_addr = newest_r[SW-1:0];
      next_wr_data = LW'(tgt_r);
      prev_wr_en   = 1'b1;
    end else if (cmd.append_b) begin
      next_wr_en   = 1'b1;
    end
  end

  assign key_wr_en = cmd.append_a;

  fept_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS), .AW(SW)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (tgt_r),
    .wr_data (key_r),
    .rd_en   (key_rd_en),
    .rd_addr (rd_cnt_r[SW-1:0]),
    .rd_data (key_rd)
  );

  // Payload is stored with the entry; no result depends on it.
  fept_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_SLOTS), .AW(SW)) u_pay_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (tgt_r),
    .wr_data (pay_r),
    .rd_en   (1'b0),
    .rd_addr (tgt_r),
    .rd_data ()
  );

  fept_ram #(.WIDTH(LW), .DEPTH(TABLE_SLOTS), .AW(SW)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_wr_en),
    .wr_addr (next_wr_addr),
    .wr_data (next_wr_data),
    .rd_en   (cmd.link_rd),
    .rd_addr (link_addr),
    .rd_data (next_rd)
  );

  fept_ram #(.WIDTH(LW), .DEPTH(TABLE_SLOTS), .AW(SW)) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_wr_en),
    .wr_addr (prev_wr_addr),
    .wr_data (prev_wr_data),
    .rd_en   (cmd.link_rd),
    .rd_addr (link_addr),
    .rd_data (prev_rd)
  );

  // Result register, loaded once the request is complete.
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      res_status  <= STAT_OK;
      res_slot    <= '0;
      res_evicted <= 1'b0;
      case (req_r)
        REQ_ADD: begin
          if (hit_r) begin
            res_status <= STAT_PRESENT;
          end else begin
            res_slot    <= SLOT_OUT_W'(tgt_r);
            res_evicted <= evict_r;
          end
        end
        REQ_REMOVE: begin
          if (!evict_r && !sts.sel_ok) begin
            res_status <= STAT_UNUSED;
          end
        end
        REQ_LOOKUP: begin
          if (hit_r) begin
            res_slot <= SLOT_OUT_W'(hit_idx_r);
          end else begin
            res_status <= STAT_NOT_FOUND;
          end
        end
        default: begin
          res_status <= STAT_OK;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Both list ends are empty together or set together.
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r == NONE) == (newest_r == NONE))
    else $error("list ends disagree on emptiness");

  // A slot is filled only when it is free.
  a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append_b |-> !used_r[tgt_r])
    else $error("append into a used slot");
`endif

endmodule

`default_nettype wire

@@ rtl/fept_ctrl.sv @@
// Controller of the peer table: sequences scan, unlink and append steps and
// owns the input ready and output valid of the stream ports.
// Depends on fept_pkg.
`default_nettype none

module fept_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire fept_pkg::sts_t sts,
  output fept_pkg::cmd_t      cmd
);
  import fept_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.req == REQ_ADD || sts.req == REQ_LOOKUP) begin
          state_nxt = S_SCAN;
        end else if (sts.req == REQ_REMOVE && sts.sel_ok) begin
          state_nxt = S_LINK_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          if (sts.req != REQ_ADD || sts.scan_hit) begin
            state_nxt = S_RESP;
          end else if (sts.free_any) begin
            cmd.take_free = 1'b1;
            state_nxt     = S_APPEND_A;
          end else begin
            state_nxt = S_LINK_RD;
          end
        end
      end
      S_LINK_RD: begin
        cmd.link_rd = 1'b1;
        state_nxt   = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = (sts.req == REQ_ADD) ? S_APPEND_A : S_RESP;
      end
      S_APPEND_A: begin
        cmd.append_a = 1'b1;
        state_nxt    = S_APPEND_B;
      end
      S_APPEND_B: begin
        cmd.append_b = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.resp_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted word is dispatched in the next cycle.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISPATCH))
    else $error("accepted word not dispatched");

  // A new result appears only out of the response state.
  a_resp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result raised outside response state");

  // Unlinking always follows the link read.
  a_unlink_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNLINK) |-> ($past(state_r) == S_LINK_RD))
    else $error("unlink without link read");
`endif

endmodule

`default_nettype wire

@@ rtl/fifo_evicting_peer_table_top.sv @@
// Top level of the FIFO-evicting peer table: stream ports, controller and
// datapath. Depends on fept_pkg, fept_ctrl, fept_dp and fept_ram.
`default_nettype none

// A table of TABLE_SLOTS peer entries keyed by 32-bit IPv4 address, kept in
// insertion order by a doubly linked list. Add stores a new key in the lowest
// free slot, or evicts the oldest entry when the table is full, and rejects a
// key already present. Remove frees a slot by index; lookup returns the slot
// holding a key. One request is handled at a time and gives one result word.
// Add and lookup scan the key memory one slot per cycle, with early exit on a
// hit. An add into a free slot then appends the entry; an add that evicts
// first reads the links of the oldest entry and unlinks it. A valid remove
// reads and unlinks the selected entry; a remove of an unused slot or an
// unknown request goes from dispatch straight to the response. A result
// appears in the same cycle as the next word can be accepted. The next request
// is accepted while the previous result waits on the output; its own result
// then waits until the output register is free. No clearing pass is needed
// after reset.
module fifo_evicting_peer_table_top #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] peer_key, [63:32] peer_payload, [67:64] slot_sel, [71:68] zero
  input  wire logic [71:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [5:2] slot_out, [6] evicted, [7] zero
  output logic [7:0]       out_tdata
);
  import fept_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [STAT_W-1:0]     res_status;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic                  res_evicted;

  fept_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fept_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_pay      (in_tdata[63:32]),
    .in_sel      (in_tdata[67:64]),
    .res_status  (res_status),
    .res_slot    (res_slot),
    .res_evicted (res_evicted)
  );

  // Result word packing.
  assign out_tdata = {1'b0, res_evicted, res_slot, res_status};

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for fifo_evicting_peer_table_top: add, remove and lookup
// requests against a cycle-free model of the slot table and its insertion-order list.
// Depends on fept_pkg and the RTL of the peer table.

// Tracks the table contents and the queue of replies still owed by the block.
class peer_table_tracker;
  localparam int SLOTS = 16;
  localparam bit [4:0] NO_SLOT = 5'd16;

  // Laid out as in the reply word: status in the lowest bits.
  typedef struct packed {
    logic       evicted;
    logic [3:0] slot;
    logic [1:0] status;
  } reply_t;

  bit [31:0] key_tbl[SLOTS];
  bit        used_tbl[SLOTS];
  bit [4:0]  next_tbl[SLOTS];
  bit [4:0]  prev_tbl[SLOTS];
  bit [4:0]  oldest;
  bit [4:0]  newest;
  reply_t    replies_due[$];

  int errors;
  int checked;
  int evictions;
  int dup_rejects;
  int lookup_hits;
  int lookup_misses;
  int bad_removes;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      key_tbl[i]  = '0;
      used_tbl[i] = 1'b0;
      next_tbl[i] = '0;
      prev_tbl[i] = '0;
    end
    oldest = NO_SLOT;
    newest = NO_SLOT;
  endfunction

  // Walk the list from the oldest entry, visiting used slots only.
  function bit locate(input bit [31:0] key, output bit [3:0] slot);
    bit [4:0] cur;
    cur  = oldest;
    slot = '0;
    for (int n = 0; n < SLOTS; n++) begin
      if (cur >= NO_SLOT || !used_tbl[cur[3:0]]) return 1'b0;
      if (key_tbl[cur[3:0]] == key) begin
        slot = cur[3:0];
        return 1'b1;
      end
      cur = next_tbl[cur[3:0]];
    end
    return 1'b0;
  endfunction

  // Take a slot out of the list and clear it.
  function void detach(input bit [3:0] s);
    bit [4:0] p;
    bit [4:0] n;
    p = prev_tbl[s];
    n = next_tbl[s];
    if (oldest == {1'b0, s}) oldest = n;
    if (newest == {1'b0, s}) newest = p;
    if (p < NO_SLOT) next_tbl[p[3:0]] = n;
    if (n < NO_SLOT) prev_tbl[n[3:0]] = p;
    key_tbl[s]  = '0;
    prev_tbl[s] = '0;
    next_tbl[s] = '0;
    used_tbl[s] = 1'b0;
  endfunction

  // Apply one accepted request to the table and queue the reply it must produce.
  function void note_request(input bit [1:0] req, input bit [31:0] key, input bit [3:0] sel);
    reply_t r;
    bit [3:0] s;
    bit got;
    r = '0;
    s = '0;
    case (req)
      fept_pkg::REQ_ADD: begin
        if (locate(key, s)) begin
          r.status = fept_pkg::STAT_PRESENT;
        end else begin
          got = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!got && !used_tbl[i]) begin
              s   = i[3:0];
              got = 1'b1;
            end
          end
          // Table full: the oldest entry makes room for the new one.
          if (!got) begin
            s = (oldest < NO_SLOT) ? oldest[3:0] : 4'd0;
            if (used_tbl[s]) detach(s);
            r.evicted = 1'b1;
          end
          key_tbl[s] = key;
          if (newest >= NO_SLOT) oldest = {1'b0, s};
          else next_tbl[newest[3:0]] = {1'b0, s};
          prev_tbl[s] = newest;
          next_tbl[s] = NO_SLOT;
          newest      = {1'b0, s};
          used_tbl[s] = 1'b1;
          r.slot      = s;
        end
      end
      fept_pkg::REQ_REMOVE: begin
        if (!used_tbl[sel]) r.status = fept_pkg::STAT_UNUSED;
        else detach(sel);
      end
      fept_pkg::REQ_LOOKUP: begin
        if (locate(key, s)) r.slot = s;
        else r.status = fept_pkg::STAT_NOT_FOUND;
      end
      default: begin
      end
    endcase
    replies_due.push_back(r);
  endfunction

  // Compare one reply word with the oldest expectation.
  function void check_reply(input bit [7:0] word);
    reply_t want;
    reply_t got;
    got = word[6:0];
    if (replies_due.size() == 0) begin
      $error("reply 0x%02h arrived with no request outstanding", word);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    checked++;
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.slot != want.slot) begin
      $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
      errors++;
    end
    if (got.evicted != want.evicted) begin
      $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
      errors++;
    end
    if (want.evicted) evictions++;
    case (want.status)
      fept_pkg::STAT_PRESENT:   dup_rejects++;
      fept_pkg::STAT_NOT_FOUND: lookup_misses++;
      fept_pkg::STAT_UNUSED:    bad_removes++;
      default: begin
      end
    endcase
  endfunction
endclass

module testbench;
  import fept_pkg::*;

  // Request code the block must answer with an all-zero reply.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 250;

  // Receiver behaviors.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_MOSTLY  = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  peer_table_tracker tracker = new();

  bit [31:0] key_pool[POOL_SIZE];
  int        rx_mode = RX_ALWAYS;
  bit        hold_wanted = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        rx_tick = 0;

  fifo_evicting_peer_table_top #(.TABLE_SLOTS(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: one long hold-off when asked, otherwise the phase's stall pattern.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_wanted && !hold_done) begin
      out_tready <= 1'b0;
      hold_left = 399;
      hold_done = 1'b1;
    end else begin
      case (rx_mode)
        RX_COIN:    out_tready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_tready <= ((rx_tick % 7) >= 3);
        RX_MOSTLY:  out_tready <= ($urandom_range(0, 9) != 0);
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // Every reply word taken by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_reply(out_tdata);
  end

  // Offer one request word and hold it until the block takes it.
  task automatic send_request(input logic [1:0] req, input logic [31:0] key,
                              input logic [31:0] pay, input logic [3:0] sel);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, sel, pay, key};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(req, key, sel);
  endtask

  // Hold the input off until every outstanding reply has come back.
  task automatic wait_drained();
    while (tracker.replies_due.size() != 0) @(posedge clk);
  endtask

  // Known corner cases: empty table, duplicate keys, extreme keys and slots.
  task automatic directed_checks();
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 4'd0);
    send_request(REQ_REMOVE, 32'h0000_0000, 32'h0, 4'd0);
    send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(REQ_ADD, 32'h0000_0000, 32'h1234_5678, 4'd0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
    send_request(REQ_LOOKUP, 32'hC0A8_0001, 32'h0, 4'd0);
    send_request(REQ_REMOVE, 32'h0, 32'h0, 4'd15);
    send_request(REQ_REMOVE, 32'h0, 32'h0, 4'd0);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0, 4'd0);
    send_request(REQ_ADD, 32'h0A00_0001, 32'hDEAD_BEEF, 4'd0);
    send_request(REQ_LOOKUP, 32'h0A00_0001, 32'h0, 4'd0);
    send_request(REQ_REMOVE, 32'h0, 32'h0, 4'd1);
    send_request(REQ_REMOVE, 32'h0, 32'h0, 4'd0);
    send_request(REQ_LOOKUP, 32'h0A00_0001, 32'h0, 4'd0);
    send_request(REQ_REMOVE, 32'h0, 32'h0, 4'd0);
  endtask

  // Random requests in bursts; keys mostly come from a pool larger than the table
  // so that duplicates, hits, misses and evictions all occur.
  task automatic run_phase(input int add_w, input int rem_w, input int look_w,
                           input bit gaps_on);
    int left;
    int burst;
    int gap;
    int pick;
    logic [1:0]  req;
    logic [31:0] key;
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && left > 0; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_w) req = REQ_ADD;
        else if (pick < add_w + rem_w) req = REQ_REMOVE;
        else if (pick < add_w + rem_w + look_w) req = REQ_LOOKUP;
        else req = REQ_UNKNOWN;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = $urandom;
        send_request(req, key, $urandom, 4'($urandom_range(0, 15)));
        left--;
      end
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_checks();
    in_tvalid <= 1'b0;
    wait_drained();

    // Fill and evict, then a long receiver hold-off while the sender keeps going.
    rx_mode = RX_COIN;
    run_phase(60, 10, 25, 1'b1);
    rx_mode = RX_MOSTLY;
    hold_wanted = 1'b1;
    run_phase(40, 25, 30, 1'b1);
    rx_mode = RX_PATTERN;
    run_phase(20, 50, 25, 1'b1);
    rx_mode = RX_ALWAYS;
    run_phase(30, 15, 50, 1'b0);
    rx_mode = RX_COIN;
    run_phase(50, 20, 25, 1'b0);
    rx_mode = RX_PATTERN;
    run_phase(35, 35, 25, 1'b1);
    rx_mode = RX_MOSTLY;
    run_phase(45, 15, 35, 1'b1);

    wait_drained();
    repeat (40) @(posedge clk);

    $display("Checked %0d replies: %0d evictions, %0d duplicate keys rejected,",
             tracker.checked, tracker.evictions, tracker.dup_rejects);
    $display("%0d lookup misses and %0d removes of free slots.",
             tracker.lookup_misses, tracker.bad_removes);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/fept_pkg.sv
rtl/fept_ram.sv
rtl/fept_dp.sv
rtl/fept_ctrl.sv
rtl/fifo_evicting_peer_table_top.sv
verif/testbench.sv
